// ===== rtl/core/zxr_pkg.sv =====
// shared types and constants of the zone expander responder
package zxr_pkg;

    // configuration
    localparam int MODULES_DEF           = 4;
    localparam int FAULT_QUEUE_DEPTH_DEF = 16;
    localparam int CFG_REGS              = 4;
    localparam int CFG_IDX_W             = 2;
    localparam int ADDR_W                = 4;
    localparam int BYTE_W                = 8;
    localparam int ZONE_W                = 6;

    // item kinds
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_ZONE    = 1'b1;

    // request types
    localparam logic [BYTE_W-1:0] TYPE_MSG     = 8'hF1;
    localparam logic [BYTE_W-1:0] TYPE_POLL    = 8'hF0;
    localparam logic [BYTE_W-1:0] TYPE_RELAY_A = 8'h00;
    localparam logic [BYTE_W-1:0] TYPE_RELAY_B = 8'h0D;

    // sequence byte handling
    localparam logic [BYTE_W-1:0] SEQ_MAGIC = 8'hDE;
    localparam logic [BYTE_W-1:0] SEQ_ALT   = 8'h34;
    localparam logic [BYTE_W-1:0] SEQ_NORM  = 8'h31;

    // address windows
    localparam logic [ADDR_W-1:0] ZONE_ADDR_LO  = 4'd7;
    localparam logic [ADDR_W-1:0] ZONE_ADDR_HI  = 4'd11;
    localparam logic [ADDR_W-1:0] NORM_ADDR_LO  = 4'd6;
    localparam logic [ADDR_W-1:0] NORM_ADDR_HI  = 4'd13;
    localparam logic [ADDR_W-1:0] FLAG_ADDR_LO  = 4'd13;

    localparam logic [BYTE_W-1:0] RELAY_SET_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] RELAY_DATA_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] OPEN_FLAG      = 8'h08;

    // reply framing
    localparam int REPLY_BEATS = 5;
    localparam logic [2:0] LAST_BEAT = 3'(REPLY_BEATS - 1);

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] req_flags;
        logic [BYTE_W-1:0] req_b3;
        logic [BYTE_W-1:0] req_b4;
        logic [BYTE_W-1:0] req_b5;
        logic [BYTE_W-1:0] req_b6;
        logic [ZONE_W-1:0] zone;
        logic              zone_open;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] resp_byte;
        logic              last;
    } resp_t;

    // one fault queue entry
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] relays;
        logic [BYTE_W-1:0] code;
    } snap_t;

    // queue control from the core
    typedef struct packed {
        logic  push;
        snap_t push_data;
        logic  pop;
    } qctl_t;

    // queue status to the core
    typedef struct packed {
        logic  empty;
        snap_t head;
    } qstat_t;

endpackage

// ===== rtl/core/zxr_fault_queue.sv =====
// ring queue of fault snapshots in a synchronous memory with head read-ahead
module zxr_fault_queue #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  zxr_pkg::qctl_t ctl,
    output zxr_pkg::qstat_t stat
);
    import zxr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    snap_t            mem_q [DEPTH];
    snap_t            rdata_reg;
    snap_t            fwd_data_reg;
    logic             fwd_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;

    // no full check: a write past the reader wraps over unread entries
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (ctl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            // a write landing on the entry being read ahead is bypassed
            fwd_reg    <= ctl.push && (wr_ptr_reg == rd_ptr_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem_q[wr_ptr_reg] <= ctl.push_data;
        end
        rdata_reg    <= mem_q[rd_ptr_next];
        fwd_data_reg <= ctl.push_data;
    end

    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);
    assign stat.head  = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

// ===== rtl/core/zone_expander_responder.sv =====
// top level of the zone expander responder
//
// Emulates up to MODULES expander slots on an alarm bus. A zone event beat
// updates the fault code and fault bitmap of the slot whose zone window holds
// the zone and pushes a snapshot into the fault queue, with no reply. A panel
// request beat that matches a slot address and has a known type is answered
// with five reply beats (four bytes, then the checksum with last set). The
// reply port drains one beat per cycle while resp_stall is low; a request
// holds the serializer until its last beat is taken. Zone events and
// unanswered requests run at one item per cycle unless a staged request waits
// on the serializer. One item is staged while a reply drains, so the input
// is taken while the reply waits on its consumer. The fault queue lives in a
// FAULT_QUEUE_DEPTH-entry synchronous memory whose head is read ahead every
// cycle with a bypass for a write to the same entry; it needs no clearing
// pass, entries are only read after being written. Slot addresses are to be
// set on the cfg port only while the block is idle; this is not enforced.
module zone_expander_responder #(
    parameter int MODULES           = zxr_pkg::MODULES_DEF,
    parameter int FAULT_QUEUE_DEPTH = zxr_pkg::FAULT_QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [zxr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [zxr_pkg::ADDR_W-1:0]         cfg_data,
    // item channel
    input  logic                               req_valid,
    output logic                               req_stall,
    input  zxr_pkg::req_t                      req,
    // reply channel
    output logic                               resp_valid,
    input  logic                               resp_stall,
    output zxr_pkg::resp_t                     resp
);
    import zxr_pkg::*;

    localparam int SLOT_W = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int BUF_W  = REPLY_BEATS * BYTE_W;

    // slot state
    logic [ADDR_W-1:0] module_addr_reg [MODULES];
    logic [BYTE_W-1:0] fault_bits_reg  [MODULES];
    logic [BYTE_W-1:0] fault_code_reg  [MODULES];
    logic [BYTE_W-1:0] relays_reg      [MODULES];

    // staged item
    logic s1_valid_reg;
    req_t s1_item_reg;

    // reply serializer
    logic             busy_reg;
    logic [2:0]       beat_cnt_reg;
    logic [BUF_W-1:0] resp_buf_reg;

    // queue
    qctl_t  q_ctl;
    qstat_t q_stat;

    // decode of the staged item
    logic              flagpath;
    logic              zfound;
    logic [SLOT_W-1:0] zhit;
    logic              rfound;
    logic [SLOT_W-1:0] rhit;
    logic [BYTE_W-1:0] seq_b;
    logic [BYTE_W-1:0] type_b;
    logic [BYTE_W-1:0] data_b;
    logic [ADDR_W-1:0] raddr;
    logic              is_msg;
    logic              is_poll;
    logic              is_relay;
    logic              head_match;
    logic              reply_en;
    logic              zone_en;
    logic [2:0]        zmod;
    logic [BYTE_W-1:0] new_code;
    logic [BYTE_W-1:0] zmask;
    logic [BYTE_W-1:0] new_bits;
    logic [BYTE_W-1:0] new_relays;
    logic [BYTE_W-1:0] r0;
    logic [BYTE_W-1:0] r1;
    logic [BYTE_W-1:0] r2;
    logic [BYTE_W-1:0] r3;
    logic [BYTE_W+1:0] sum4;
    logic [BYTE_W-1:0] chk;
    logic              ser_free;
    logic              exec;
    logic              req_acc;
    logic              resp_acc;

    // slot search: first slot wins
    always_comb
    begin
        logic [ADDR_W-1:0] a;
        logic [ZONE_W-1:0] zm1;
        logic [ADDR_W-1:0] d_norm;
        logic [ADDR_W-1:0] d_flag;
        logic [ADDR_W-1:0] d_zone;
        logic              zc;
        logic              rc;
        zfound   = 1'b0;
        zhit     = '0;
        rfound   = 1'b0;
        rhit     = '0;
        flagpath = s1_item_reg.req_flags[0];
        zm1      = s1_item_reg.zone - 1'b1;
        for (int i = 0; i < MODULES; i++)
        begin
            a      = module_addr_reg[i];
            d_norm = a - NORM_ADDR_LO;
            d_flag = a - FLAG_ADDR_LO;
            d_zone = a - NORM_ADDR_LO;
            // zone window of a slot is 8*(addr-6)+1 .. 8*(addr-6)+8
            zc = (a >= ZONE_ADDR_LO) && (a <= ZONE_ADDR_HI)
                 && (s1_item_reg.zone != '0) && (zm1[5:3] == d_zone[2:0]);
            if (flagpath)
            begin
                rc = (a >= FLAG_ADDR_LO)
                     && (s1_item_reg.req_b3 == (BYTE_W'(1) << d_flag[2:0]));
            end
            else
            begin
                rc = (a >= NORM_ADDR_LO) && (a <= NORM_ADDR_HI)
                     && (s1_item_reg.req_flags == (BYTE_W'(1) << d_norm[2:0]));
            end
            if (!zfound && zc)
            begin
                zfound = 1'b1;
                zhit   = SLOT_W'(i);
            end
            if (!rfound && rc)
            begin
                rfound = 1'b1;
                rhit   = SLOT_W'(i);
            end
        end
    end

    // request and zone event work
    always_comb
    begin
        seq_b  = flagpath ? s1_item_reg.req_b4 : s1_item_reg.req_b3;
        type_b = flagpath ? s1_item_reg.req_b5 : s1_item_reg.req_b4;
        data_b = flagpath ? s1_item_reg.req_b6 : s1_item_reg.req_b5;
        raddr  = module_addr_reg[rhit];

        is_msg   = (type_b == TYPE_MSG);
        is_poll  = (type_b == TYPE_POLL);
        is_relay = (type_b == TYPE_RELAY_A) || (type_b == TYPE_RELAY_B);

        head_match = !q_stat.empty && (q_stat.head.addr != '0)
                     && (q_stat.head.addr == raddr);

        reply_en = (s1_item_reg.cmd == CMD_REQUEST) && rfound
                   && (is_msg || is_poll || is_relay);
        zone_en  = (s1_item_reg.cmd == CMD_ZONE) && zfound;

        // zone event: code is zone mod 8 in the top bits plus the open flag
        zmod     = s1_item_reg.zone[2:0];
        new_code = {zmod, 5'd0} | (s1_item_reg.zone_open ? OPEN_FLAG : '0);
        // zone mod 8 = 1 maps to the top bit, 0 wraps to the bottom bit
        zmask    = BYTE_W'(1) << (3'd0 - zmod);
        new_bits = s1_item_reg.zone_open ? (fault_bits_reg[zhit] | zmask)
                                         : (fault_bits_reg[zhit] & ~zmask);

        // relay command: bit 7 chooses set or clear of the low bits
        if ((data_b & RELAY_SET_MASK) != '0)
        begin
            new_relays = relays_reg[rhit] | (data_b & RELAY_DATA_MASK);
        end
        else
        begin
            new_relays = relays_reg[rhit] & ~(data_b & RELAY_DATA_MASK);
        end

        r1 = (seq_b == SEQ_MAGIC) ? SEQ_ALT : SEQ_NORM;
        priority if (is_msg && head_match)
        begin
            r0 = BYTE_W'(q_stat.head.addr);
            r2 = q_stat.head.relays;
            r3 = q_stat.head.code;
        end
        else if (is_msg)
        begin
            r0 = BYTE_W'(raddr);
            r2 = relays_reg[rhit];
            r3 = fault_code_reg[rhit];
        end
        else if (is_poll)
        begin
            r0 = TYPE_POLL;
            r2 = '0;
            r3 = fault_bits_reg[rhit];
        end
        else
        begin
            r0 = BYTE_W'(raddr);
            r2 = '0;
            r3 = data_b;
        end

        sum4 = 10'(r0) + 10'(r1) + 10'(r2) + 10'(r3);
        chk  = ~(sum4[BYTE_W-1:0] - 1'b1);
    end

    // handshakes
    assign resp_acc  = resp_valid && !resp_stall;
    assign ser_free  = !busy_reg || (resp_acc && (beat_cnt_reg == LAST_BEAT));
    // an item with no reply never waits on the serializer
    assign exec      = s1_valid_reg && (!reply_en || ser_free);
    assign req_stall = s1_valid_reg && !exec;
    assign req_acc   = req_valid && !req_stall;

    // queue traffic
    assign q_ctl.push           = exec && zone_en;
    assign q_ctl.push_data.addr = module_addr_reg[zhit];
    assign q_ctl.push_data.relays = relays_reg[zhit];
    assign q_ctl.push_data.code = new_code;
    assign q_ctl.pop            = exec && reply_en && is_msg && head_match;

    zxr_fault_queue #(
        .DEPTH (FAULT_QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .stat  (q_stat)
    );

    // slot addresses, slots past the register list stay unused
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MODULES; i++)
            begin
                module_addr_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < MODULES; i++)
            begin
                if ((i < CFG_REGS) && (cfg_index == CFG_IDX_W'(i)))
                begin
                    module_addr_reg[i] <= cfg_data;
                end
            end
        end
    end

    // slot fault and relay state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MODULES; i++)
            begin
                fault_bits_reg[i] <= '0;
                fault_code_reg[i] <= '0;
                relays_reg[i]     <= '0;
            end
        end
        else if (exec)
        begin
            if (zone_en)
            begin
                fault_bits_reg[zhit] <= new_bits;
                fault_code_reg[zhit] <= new_code;
            end
            if (reply_en && is_relay)
            begin
                relays_reg[rhit] <= new_relays;
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (exec)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_item_reg <= req;
        end
    end

    // reply serializer: shifts out one byte per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            beat_cnt_reg <= '0;
        end
        else if (exec && reply_en)
        begin
            busy_reg     <= 1'b1;
            beat_cnt_reg <= '0;
        end
        else if (resp_acc)
        begin
            if (beat_cnt_reg == LAST_BEAT)
            begin
                busy_reg <= 1'b0;
            end
            beat_cnt_reg <= beat_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec && reply_en)
        begin
            resp_buf_reg <= {r0, r1, r2, r3, chk};
        end
        else if (resp_acc)
        begin
            resp_buf_reg <= {resp_buf_reg[BUF_W-BYTE_W-1:0], BYTE_W'(0)};
        end
    end

    assign resp_valid     = busy_reg;
    assign resp.resp_byte = resp_buf_reg[BUF_W-1 -: BYTE_W];
    assign resp.last      = (beat_cnt_reg == LAST_BEAT);

endmodule

// ===== rtl/core/zxr_checker.sv =====
// port checker of the zone expander responder and its bind
module zxr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           resp_valid,
    input logic           resp_stall,
    input zxr_pkg::resp_t resp
);
    import zxr_pkg::*;

    logic [2:0]        beat_cnt_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic              resp_acc;

    assign resp_acc = resp_valid && !resp_stall;

    // running beat count and byte sum of the reply in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= '0;
            sum_reg      <= '0;
        end
        else if (resp_acc)
        begin
            if (resp.last)
            begin
                beat_cnt_reg <= '0;
                sum_reg      <= '0;
            end
            else
            begin
                beat_cnt_reg <= beat_cnt_reg + 1'b1;
                sum_reg      <= sum_reg + resp.resp_byte;
            end
        end
    end

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp_stall |=> resp_valid && $stable(resp))
        else $error("reply beat changed while stalled");

    a_five_beats: assert property (@(posedge clk) disable iff (!rst_n)
        resp_acc |-> (resp.last == (beat_cnt_reg == LAST_BEAT)))
        else $error("reply is not five beats long");

    a_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        resp_acc && resp.last |-> resp.resp_byte == BYTE_W'(~(sum_reg - 1'b1)))
        else $error("bad reply checksum");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> $past(req_valid && !req_stall) || $past(req_stall))
        else $error("input stalled with no item held");

endmodule

bind zone_expander_responder zxr_checker u_zxr_checker (.*);
